### src/cpra_pkg.sv
`default_nettype none
package cpra_pkg;

	localparam int Segments    = 8;
	localparam int PagesPerSeg = 32;
	localparam int PageBytes   = 4096;

	localparam int SegW      = $clog2(Segments);
	localparam int OffW      = $clog2(PagesPerSeg);
	localparam int LenW      = $clog2(PagesPerSeg + 1);
	localparam int AddrW     = SegW + OffW;
	localparam int NumPages  = Segments * PagesPerSeg;
	localparam int PageShift = $clog2(PageBytes);
	localparam int MaskW     = 2 * PagesPerSeg;

	localparam int ReqBytesW = 18;
	localparam int NodeW     = 3;
	localparam int InSegW    = 3;
	localparam int InOffW    = 5;
	localparam int CfgW      = 4;
	localparam int PaddrW    = 3;

	localparam logic [PaddrW-1:0] AddrNodeCount = 3'd0;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic            hit;
		logic [OffW-1:0] offset;
	} run_hit_t;

	function automatic logic [PagesPerSeg-1:0] run_mask(input logic [OffW-1:0] off,
		input logic [LenW-1:0] len);
		logic [MaskW-1:0] w;
		w = (MaskW'(1) << len) - MaskW'(1);
		w = w << off;
		return w[PagesPerSeg-1:0];
	endfunction

endpackage
`default_nettype wire

### src/contiguous_page_run_allocator.sv
// First-fit allocator of contiguous page runs over a per-page bitmap.
// Requests arrive on the s_ stream; s_tuser carries the operation (allocate,
// free, query) and s_tdata the size, node and run location. Each request
// produces exactly one result on the m_ stream: m_tuser carries the status,
// m_tdata the segment, start page and run length.
// An allocate goes from S_IDLE to S_SCAN, where one segment of the node's
// range is examined per cycle by a single run detector until a fit or the
// last segment, and then to S_REPLY to post the result. An allocate that is
// rejected or whose node owns no segments, and an unknown operation, go
// straight to S_REPLY. Free and query check the run length read at the
// transfer in S_LOOKUP, then post the result in S_REPLY. The block accepts a
// new request only while idle, which it is again the cycle after a result is
// posted, so a request is not taken before the last one's result is posted.
// A finished result sits in the output register; if the receiver stalls, the
// next request is still accepted and processed, and its result waits until
// the output register is taken. Reset clears the bitmap, marks every start
// page as holding no run and sets node_count to one. The node_count register
// is written through the APB port and should change only while idle.
`default_nettype none
module contiguous_page_run_allocator import cpra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	// request_bytes[17:0], node[20:18], segment[23:21], page_offset[28:24], zero pad
	input  logic [31:0]       s_tdata,
	// operation[1:0]
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// found_segment[2:0], found_offset[7:3], run_pages[13:8], zero pad
	output logic [15:0]       m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);

	state_t state_q, state_d;

	logic [CfgW-1:0] node_count_q;

	op_t             op_q;
	logic [LenW-1:0] pages_q;
	logic [SegW:0]   seg_q;
	logic [SegW:0]   seg_end_q;
	logic [AddrW-1:0] addr_q;

	status_t         res_status_q;
	logic [SegW-1:0] res_seg_q;
	logic [OffW-1:0] res_off_q;
	logic [LenW-1:0] res_len_q;

	logic            out_valid_q;
	status_t         out_status_q;
	logic [SegW-1:0] out_seg_q;
	logic [OffW-1:0] out_off_q;
	logic [LenW-1:0] out_len_q;

	logic [PagesPerSeg-1:0] page_map_q [Segments];
	logic [NumPages-1:0]    len_vld_q;
	logic [LenW-1:0]        len_mem [NumPages];
	logic [LenW-1:0]        len_rd_q;

	logic [ReqBytesW-1:0] in_bytes;
	logic [NodeW-1:0]     in_node;
	logic [InSegW-1:0]    in_seg;
	logic [InOffW-1:0]    in_off;
	logic [ReqBytesW:0]   bytes_up;
	logic [ReqBytesW-PageShift:0] in_pages;
	logic [CfgW-1:0]      nc_eff;
	logic [SegW:0]        rng;
	logic [SegW+NodeW:0]  first_full;
	logic [SegW:0]        first;
	logic                 alloc_bad;
	logic [AddrW-1:0]     in_addr;

	logic            accept;
	logic            out_free;
	logic            load_out;
	logic            scan_take;
	logic            seg_last;
	logic            lookup_vld;
	logic [SegW-1:0] seg_idx;
	logic [SegW-1:0] addr_seg;
	logic [OffW-1:0] addr_off;
	logic [PagesPerSeg-1:0] take_mask;
	logic [PagesPerSeg-1:0] free_mask;
	run_hit_t        find_res;

	assign pready = 1'b1;
	assign prdata = (paddr == AddrNodeCount) ? 32'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CfgW'(1);
		end else if (psel && penable && pwrite && pready && paddr == AddrNodeCount) begin
			node_count_q <= pwdata[CfgW-1:0];
		end
	end

	always_comb begin
		in_bytes = s_tdata[ReqBytesW-1:0];
		in_node  = s_tdata[ReqBytesW +: NodeW];
		in_seg   = s_tdata[ReqBytesW+NodeW +: InSegW];
		in_off   = s_tdata[ReqBytesW+NodeW+InSegW +: InOffW];
		in_addr  = {in_seg[SegW-1:0], in_off[OffW-1:0]};
		bytes_up = {1'b0, in_bytes} + (ReqBytesW+1)'(PageBytes - 1);
		in_pages = bytes_up[ReqBytesW:PageShift];
		nc_eff   = (node_count_q == '0) ? CfgW'(1) : node_count_q;
		rng      = '0;
		for (int r = 1; r <= Segments; r++) begin
			if (r * int'(nc_eff) <= Segments) begin
				rng = (SegW+1)'(r);
			end
		end
		first_full = rng * in_node;
		first      = first_full[SegW:0];
		alloc_bad  = (in_pages == '0) || (in_pages > PagesPerSeg) ||
			({1'b0, in_node} >= nc_eff);
	end

	assign seg_idx   = seg_q[SegW-1:0];
	assign addr_seg  = addr_q[AddrW-1:OffW];
	assign addr_off  = addr_q[OffW-1:0];
	assign take_mask = run_mask(find_res.offset, pages_q);
	assign free_mask = run_mask(addr_off, len_rd_q);

	cpra_run_find u_find (
		.used   (page_map_q[seg_idx]),
		.pages  (pages_q),
		.result (find_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						OP_ALLOC: state_d = (alloc_bad || rng == '0) ? S_REPLY : S_SCAN;
						OP_FREE, OP_QUERY: state_d = S_LOOKUP;
						default: state_d = S_REPLY;
					endcase
				end
			end
			S_SCAN: begin
				if (find_res.hit || seg_last) begin
					state_d = S_REPLY;
				end
			end
			S_LOOKUP: state_d = S_REPLY;
			S_REPLY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		s_tready   = (state_q == S_IDLE);
		accept     = s_tvalid && s_tready;
		out_free   = !out_valid_q || m_tready;
		load_out   = (state_q == S_REPLY) && out_free;
		scan_take  = (state_q == S_SCAN) && find_res.hit;
		seg_last   = (seg_q + (SegW+1)'(1)) >= seg_end_q;
		lookup_vld = (state_q == S_LOOKUP) && len_vld_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(s_tuser);
			pages_q   <= LenW'(in_pages);
			seg_q     <= first;
			seg_end_q <= first + rng;
			addr_q    <= in_addr;
			res_status_q <= (s_tuser == OP_ALLOC && !alloc_bad) ? ST_NOFIT : ST_BAD;
			res_seg_q <= '0;
			res_off_q <= '0;
			res_len_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (find_res.hit) begin
				res_status_q <= ST_OK;
				res_seg_q    <= seg_idx;
				res_off_q    <= find_res.offset;
				res_len_q    <= pages_q;
			end else begin
				seg_q <= seg_q + (SegW+1)'(1);
			end
		end
		if (lookup_vld) begin
			res_status_q <= ST_OK;
			res_seg_q    <= addr_seg;
			res_off_q    <= addr_off;
			res_len_q    <= len_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < Segments; s++) begin
				page_map_q[s] <= '0;
			end
			len_vld_q <= '0;
		end else if (scan_take) begin
			page_map_q[seg_idx] <= page_map_q[seg_idx] | take_mask;
			len_vld_q[{seg_idx, find_res.offset}] <= 1'b1;
		end else if (lookup_vld && op_q == OP_FREE) begin
			page_map_q[addr_seg] <= page_map_q[addr_seg] & ~free_mask;
			len_vld_q[addr_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			len_mem[{seg_idx, find_res.offset}] <= pages_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_rd_q <= len_mem[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_seg_q    <= res_seg_q;
			out_off_q    <= res_off_q;
			out_len_q    <= res_len_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = 16'({out_len_q, out_off_q, out_seg_q});

	a_take_marks: assert property (@(posedge clk) disable iff (!arst_n)
		scan_take |=> ((page_map_q[$past(seg_idx)] & $past(take_mask)) == $past(take_mask)))
		else $error("Allocated run was not marked in the page map.");

	a_ok_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_OK) |-> (out_len_q != '0))
		else $error("Successful result carries an empty run.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |->
		(out_len_q == '0 && out_seg_q == '0 && out_off_q == '0))
		else $error("Failed result carries nonzero fields.");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (seg_q < seg_end_q))
		else $error("Scan left the node's segment range.");

endmodule
`default_nettype wire

### src/cpra_run_find.sv
`default_nettype none
module cpra_run_find import cpra_pkg::*; (
	input  logic [PagesPerSeg-1:0] used,
	input  logic [LenW-1:0]        pages,
	output run_hit_t               result
);

	logic [PagesPerSeg-1:0] len_mask;
	logic [PagesPerSeg-1:0] hit_vec;

	always_comb begin
		len_mask = run_mask('0, pages);
		for (int o = 0; o < PagesPerSeg; o++) begin
			hit_vec[o] = (((used >> o) & len_mask) == '0) &&
				((int'(pages) + o) <= PagesPerSeg);
		end
	end

	always_comb begin
		result.hit    = |hit_vec;
		result.offset = '0;
		for (int o = PagesPerSeg - 1; o >= 0; o--) begin
			if (hit_vec[o]) begin
				result.offset = OffW'(o);
			end
		end
	end

endmodule
`default_nettype wire
